/* design/htst_pkg.sv */
// Shared constants, types and the CORDIC angle table for the heading tracker.
package htst_pkg;

  localparam int ANGLE_FRAC_BITS = 6;
  localparam int CORDIC_STAGES   = 14;
  localparam int FINE_BITS       = 16;
  localparam int TABLE_IDX_W     = 5;

  localparam int POS_W   = 24;
  localparam int DIFF_W  = POS_W + 1;
  localparam int CX_W    = POS_W + 4;
  localparam int Z_W     = 28;
  localparam int ANG_W   = 15;
  localparam int ROT_W   = 16;
  localparam int RATE_W  = 17;
  localparam int ITER_W  = $clog2(CORDIC_STAGES);

  localparam int FULL_TURN   = 360 << ANGLE_FRAC_BITS;
  localparam int HALF_TURN   = 180 << ANGLE_FRAC_BITS;
  localparam int SNAP_LIM    = 1 << (ANGLE_FRAC_BITS - 2);
  localparam int ROUND_SHIFT = FINE_BITS - ANGLE_FRAC_BITS;
  localparam int Q_W         = $clog2(840 << ANGLE_FRAC_BITS);
  localparam int DMAG_W      = $clog2(HALF_TURN + 1);

  localparam int Z_BASE = (360 << FINE_BITS) + (1 << (ROUND_SHIFT - 1));
  localparam int Z_HALF = 180 << FINE_BITS;

  localparam int RATE_SHIFT = 16;
  localparam int RATE_ONE   = 1 << RATE_SHIFT;
  localparam int RATE_RND   = 1 << (RATE_SHIFT - 1);
  localparam int RATE_RESET = 6554;

  typedef enum logic [1:0] {
    OUT_EQUAL = 2'd0,
    OUT_SNAP  = 2'd1,
    OUT_LERP  = 2'd2
  } outcome_t;

  typedef logic signed [POS_W-1:0] pos_t;

  typedef struct packed {
    pos_t own_x;
    pos_t own_z;
    pos_t goal_x;
    pos_t goal_z;
    logic face_away;
  } in_item_t;

  typedef struct packed {
    logic [ANG_W-1:0] desired;
    logic             equal;
  } q_item_t;

  typedef struct packed {
    logic [ANG_W-1:0]        desired;
    logic [ANG_W-1:0]        yaw;
    logic signed [ROT_W-1:0] pitch;
    logic signed [ROT_W-1:0] roll;
    outcome_t                outcome;
  } result_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic [Z_W-1:0] atan_fine(input logic [TABLE_IDX_W-1:0] idx);
    logic [Z_W-1:0] v;
    unique case (idx)
      5'd0:    v = Z_W'(2949120);
      5'd1:    v = Z_W'(1740967);
      5'd2:    v = Z_W'(919879);
      5'd3:    v = Z_W'(466945);
      5'd4:    v = Z_W'(234379);
      5'd5:    v = Z_W'(117304);
      5'd6:    v = Z_W'(58666);
      5'd7:    v = Z_W'(29335);
      5'd8:    v = Z_W'(14668);
      5'd9:    v = Z_W'(7334);
      5'd10:   v = Z_W'(3667);
      5'd11:   v = Z_W'(1833);
      5'd12:   v = Z_W'(917);
      5'd13:   v = Z_W'(458);
      5'd14:   v = Z_W'(229);
      5'd15:   v = Z_W'(115);
      5'd16:   v = Z_W'(57);
      5'd17:   v = Z_W'(29);
      5'd18:   v = Z_W'(14);
      5'd19:   v = Z_W'(7);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

/* design/htst_front.sv */
// Front end: accept a position pair, run the iterative CORDIC atan2, queue the desired yaw.
module htst_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  htst_pkg::in_item_t  in_item,
  output logic                push_valid,
  input  logic                push_ready,
  output htst_pkg::q_item_t   push_item
);

  typedef enum logic [1:0] {F_IDLE, F_PREP, F_ITER, F_PUSH} fstate_t;

  fstate_t                                state_r, state_nxt;
  logic signed [htst_pkg::DIFF_W-1:0]     dx_r, dx_nxt, dz_r, dz_nxt;
  logic                                   face_r, face_nxt, eq_r, eq_nxt;
  logic signed [htst_pkg::CX_W-1:0]       x_r, x_nxt, y_r, y_nxt, xs, ys;
  logic signed [htst_pkg::Z_W-1:0]        z_r, z_nxt;
  logic [htst_pkg::ITER_W-1:0]            iter_r, iter_nxt;
  logic [htst_pkg::Z_W-1:0]               at;
  logic [htst_pkg::Q_W-1:0]               q, q_wrap;

  assign xs = x_r >>> iter_r;
  assign ys = y_r >>> iter_r;
  assign at = htst_pkg::atan_fine(htst_pkg::TABLE_IDX_W'(iter_r));

  // round-to-nearest bias is already in z, so a plain shift finishes it
  always_comb begin
    q = z_r[htst_pkg::ROUND_SHIFT +: htst_pkg::Q_W];
    if (q >= htst_pkg::Q_W'(2 * htst_pkg::FULL_TURN)) begin
      q_wrap = q - htst_pkg::Q_W'(2 * htst_pkg::FULL_TURN);
    end else if (q >= htst_pkg::Q_W'(htst_pkg::FULL_TURN)) begin
      q_wrap = q - htst_pkg::Q_W'(htst_pkg::FULL_TURN);
    end else begin
      q_wrap = q;
    end
  end

  assign in_ready          = (state_r == F_IDLE);
  assign push_valid        = (state_r == F_PUSH);
  assign push_item.desired = eq_r ? '0 : htst_pkg::ANG_W'(q_wrap);
  assign push_item.equal   = eq_r;

  always_comb begin
    state_nxt = state_r;
    dx_nxt    = dx_r;
    dz_nxt    = dz_r;
    face_nxt  = face_r;
    eq_nxt    = eq_r;
    x_nxt     = x_r;
    y_nxt     = y_r;
    z_nxt     = z_r;
    iter_nxt  = iter_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          dx_nxt    = htst_pkg::DIFF_W'(in_item.own_x) - htst_pkg::DIFF_W'(in_item.goal_x);
          dz_nxt    = htst_pkg::DIFF_W'(in_item.own_z) - htst_pkg::DIFF_W'(in_item.goal_z);
          face_nxt  = in_item.face_away;
          state_nxt = F_PREP;
        end
      end
      F_PREP: begin
        eq_nxt   = (dx_r == '0) && (dz_r == '0);
        iter_nxt = '0;
        // turn a leftward vector by half a turn first
        if (dz_r[htst_pkg::DIFF_W-1]) begin
          x_nxt = -htst_pkg::CX_W'(dz_r);
          y_nxt = -htst_pkg::CX_W'(dx_r);
        end else begin
          x_nxt = htst_pkg::CX_W'(dz_r);
          y_nxt = htst_pkg::CX_W'(dx_r);
        end
        z_nxt = htst_pkg::Z_W'(htst_pkg::Z_BASE)
              + (dz_r[htst_pkg::DIFF_W-1] ? htst_pkg::Z_W'(htst_pkg::Z_HALF) : '0)
              + (face_r ? htst_pkg::Z_W'(htst_pkg::Z_HALF) : '0);
        state_nxt = ((dx_r == '0) && (dz_r == '0)) ? F_PUSH : F_ITER;
      end
      F_ITER: begin
        if (y_r > 0) begin
          x_nxt = x_r + ys;
          y_nxt = y_r - xs;
          z_nxt = z_r + at;
        end else begin
          x_nxt = x_r - ys;
          y_nxt = y_r + xs;
          z_nxt = z_r - at;
        end
        iter_nxt = iter_r + 1'b1;
        if (iter_r == htst_pkg::ITER_W'(htst_pkg::CORDIC_STAGES - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    dx_r   <= dx_nxt;
    dz_r   <= dz_nxt;
    face_r <= face_nxt;
    eq_r   <= eq_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    iter_r <= iter_nxt;
  end

endmodule

/* design/htst_queue.sv */
// Two-entry queue between the angle front end and the state-update back end.
module htst_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  htst_pkg::q_item_t push_item,
  output logic              pop_valid,
  input  logic              pop_ready,
  output htst_pkg::q_item_t pop_item
);

  htst_pkg::q_item_t entry_r [2];
  logic              wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [1:0]        count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_item   = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

/* design/htst_back.sv */
// Back end: shortest-turn delta, snap or rate-scaled step, pitch and roll damping, output register.
module htst_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        pop_valid,
  output logic                        pop_ready,
  input  htst_pkg::q_item_t           pop_item,
  input  logic [htst_pkg::RATE_W-1:0] turn_rate,
  output logic                        out_valid,
  input  logic                        out_ready,
  output htst_pkg::result_t           out_res
);

  typedef enum logic [1:0] {B_IDLE, B_DELTA, B_MUL, B_DONE} bstate_t;

  localparam int SW = htst_pkg::ANG_W + 2;
  localparam int YP_W = htst_pkg::DMAG_W + htst_pkg::RATE_W;
  localparam int PP_W = htst_pkg::ROT_W + htst_pkg::RATE_W;

  bstate_t                             state_r, state_nxt;
  logic [htst_pkg::ANG_W-1:0]          des_r, des_nxt, yaw_r, yaw_nxt;
  logic                                eq_r, eq_nxt, dneg_r, dneg_nxt, snap_r, snap_nxt;
  logic [htst_pkg::DMAG_W-1:0]         dmag_r, dmag_nxt, ystep_r, ystep_nxt;
  logic [htst_pkg::RATE_W-1:0]         t_r, t_nxt;
  logic [htst_pkg::ROT_W-1:0]          pstep_r, pstep_nxt, rstep_r, rstep_nxt;
  logic signed [htst_pkg::ROT_W-1:0]   pitch_r, pitch_nxt, roll_r, roll_nxt;
  logic                                out_valid_r, out_valid_nxt;
  htst_pkg::result_t                   res_r, res_nxt;

  logic signed [SW-1:0]                d0, d1, dabs, ydelta, ysum;
  logic [YP_W-1:0]                     yprod;
  logic [YP_W:0]                       yrnd;
  logic [htst_pkg::ROT_W-1:0]          pabs, rabs;
  logic [PP_W-1:0]                     pprod, rprod;
  logic [PP_W:0]                       prnd, rrnd;
  logic [htst_pkg::ANG_W-1:0]          yaw_lerp;
  logic                                commit;

  // shortest signed delta; exactly half a turn keeps its sign
  always_comb begin
    d0 = SW'(des_r) - SW'(yaw_r);
    if (d0 > SW'(htst_pkg::HALF_TURN)) begin
      d1 = d0 - SW'(htst_pkg::FULL_TURN);
    end else if (d0 < -SW'(htst_pkg::HALF_TURN)) begin
      d1 = d0 + SW'(htst_pkg::FULL_TURN);
    end else begin
      d1 = d0;
    end
    dabs = d1[SW-1] ? -d1 : d1;
  end

  // magnitude times rate, rounded half away from zero
  always_comb begin
    pabs  = pitch_r[htst_pkg::ROT_W-1] ? -pitch_r : pitch_r;
    rabs  = roll_r[htst_pkg::ROT_W-1] ? -roll_r : roll_r;
    yprod = dmag_r * t_r;
    pprod = pabs * t_r;
    rprod = rabs * t_r;
    yrnd  = {1'b0, yprod} + (YP_W + 1)'(htst_pkg::RATE_RND);
    prnd  = {1'b0, pprod} + (PP_W + 1)'(htst_pkg::RATE_RND);
    rrnd  = {1'b0, rprod} + (PP_W + 1)'(htst_pkg::RATE_RND);
  end

  always_comb begin
    ydelta = dneg_r ? -SW'(ystep_r) : SW'(ystep_r);
    ysum   = SW'(yaw_r) + ydelta;
    if (ysum < 0) begin
      yaw_lerp = htst_pkg::ANG_W'(ysum + SW'(htst_pkg::FULL_TURN));
    end else if (ysum >= SW'(htst_pkg::FULL_TURN)) begin
      yaw_lerp = htst_pkg::ANG_W'(ysum - SW'(htst_pkg::FULL_TURN));
    end else begin
      yaw_lerp = htst_pkg::ANG_W'(ysum);
    end
  end

  assign commit    = !out_valid_r || out_ready;
  assign pop_ready = (state_r == B_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = res_r;

  always_comb begin
    state_nxt     = state_r;
    des_nxt       = des_r;
    eq_nxt        = eq_r;
    dneg_nxt      = dneg_r;
    snap_nxt      = snap_r;
    dmag_nxt      = dmag_r;
    t_nxt         = t_r;
    ystep_nxt     = ystep_r;
    pstep_nxt     = pstep_r;
    rstep_nxt     = rstep_r;
    yaw_nxt       = yaw_r;
    pitch_nxt     = pitch_r;
    roll_nxt      = roll_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          des_nxt   = pop_item.desired;
          eq_nxt    = pop_item.equal;
          state_nxt = B_DELTA;
        end
      end
      B_DELTA: begin
        dneg_nxt  = d1[SW-1];
        dmag_nxt  = htst_pkg::DMAG_W'(dabs);
        snap_nxt  = (dabs <= SW'(htst_pkg::SNAP_LIM));
        t_nxt     = (turn_rate > htst_pkg::RATE_W'(htst_pkg::RATE_ONE))
                  ? htst_pkg::RATE_W'(htst_pkg::RATE_ONE) : turn_rate;
        state_nxt = B_MUL;
      end
      B_MUL: begin
        ystep_nxt = yrnd[htst_pkg::RATE_SHIFT +: htst_pkg::DMAG_W];
        pstep_nxt = prnd[htst_pkg::RATE_SHIFT +: htst_pkg::ROT_W];
        rstep_nxt = rrnd[htst_pkg::RATE_SHIFT +: htst_pkg::ROT_W];
        state_nxt = B_DONE;
      end
      B_DONE: begin
        if (commit) begin
          res_nxt.desired = des_r;
          if (eq_r) begin
            res_nxt.outcome = htst_pkg::OUT_EQUAL;
          end else if (snap_r) begin
            yaw_nxt         = des_r;
            res_nxt.outcome = htst_pkg::OUT_SNAP;
          end else begin
            yaw_nxt         = yaw_lerp;
            pitch_nxt       = pitch_r[htst_pkg::ROT_W-1] ? pitch_r + pstep_r : pitch_r - pstep_r;
            roll_nxt        = roll_r[htst_pkg::ROT_W-1] ? roll_r + rstep_r : roll_r - rstep_r;
            res_nxt.outcome = htst_pkg::OUT_LERP;
          end
          res_nxt.yaw   = yaw_nxt;
          res_nxt.pitch = pitch_nxt;
          res_nxt.roll  = roll_nxt;
          out_valid_nxt = 1'b1;
          state_nxt     = B_IDLE;
        end
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
      yaw_r       <= '0;
      pitch_r     <= '0;
      roll_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      yaw_r       <= yaw_nxt;
      pitch_r     <= pitch_nxt;
      roll_r      <= roll_nxt;
    end
    des_r   <= des_nxt;
    eq_r    <= eq_nxt;
    dneg_r  <= dneg_nxt;
    snap_r  <= snap_nxt;
    dmag_r  <= dmag_nxt;
    t_r     <= t_nxt;
    ystep_r <= ystep_nxt;
    pstep_r <= pstep_nxt;
    rstep_r <= rstep_nxt;
    res_r   <= res_nxt;
  end

endmodule

/* design/heading_tracker_shortest_turn.sv */
// Top level of the heading tracker: stream ports, turn-rate register, front, queue and back end.
//
// Usage:
//   The input stream carries an own position, a target position (x and z, signed,
//   8 fraction bits) and a face-away flag in tuser. For each input transfer the block
//   emits exactly one result transfer: the desired yaw, the updated yaw, pitch and
//   roll (degrees times 64) and an outcome code in tuser (equal, snapped, lerped).
//   The turn rate (65536 = 1.0, larger values clamp) is written through cfg_wr_en /
//   cfg_wr_data while no item is in flight.
// Flow:
//   The front end takes one item and runs an iterative CORDIC, one rotation per
//   cycle; with setup and queue push it holds that item until the push completes,
//   and only then accepts the next. The back end takes each item through pop,
//   delta, multiply and update, then registers the result and raises out_tvalid.
//   A two-entry queue sits between the front and back ends, and the result sits in
//   an output register, so a stalled receiver holds the back end while the front
//   end keeps accepting until the queue fills.
// Reset:
//   Synchronous, active low: stored yaw, pitch and roll go to zero, the turn rate
//   to 6554, and both stream sides go idle.
module heading_tracker_shortest_turn (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // own_x[23:0], own_z[47:24], goal_x[71:48], goal_z[95:72]
  input  logic [0:0]  in_tuser,   // face_away[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // desired_yaw[14:0], new_yaw[29:15], new_pitch[45:30],
                                  // new_roll[61:46], zero pad[63:62]
  output logic [1:0]  out_tuser,  // outcome[1:0]
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data // turn_rate[16:0]
);

  logic [htst_pkg::RATE_W-1:0] turn_rate_r, turn_rate_nxt;
  htst_pkg::in_item_t          in_item;
  htst_pkg::q_item_t           push_item, pop_item;
  htst_pkg::result_t           res;
  logic                        push_valid, push_ready, pop_valid, pop_ready;

  // Hold the rate until a new write arrives
  assign turn_rate_nxt = cfg_wr_en ? cfg_wr_data : turn_rate_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_rate_r <= htst_pkg::RATE_W'(htst_pkg::RATE_RESET);
    end else begin
      turn_rate_r <= turn_rate_nxt;
    end
  end

  // Unpack the input transfer
  assign in_item.own_x     = in_tdata[23:0];
  assign in_item.own_z     = in_tdata[47:24];
  assign in_item.goal_x    = in_tdata[71:48];
  assign in_item.goal_z    = in_tdata[95:72];
  assign in_item.face_away = in_tuser[0];

  htst_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  htst_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_item   (pop_item)
  );

  htst_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_item  (pop_item),
    .turn_rate (turn_rate_r),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  // Pack the result transfer
  assign out_tdata = {2'b00, res.roll, res.pitch, res.yaw, res.desired};
  assign out_tuser = res.outcome;

  // A snapped result lands exactly on the desired yaw
  a_snap_exact: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == htst_pkg::OUT_SNAP) |-> out_tdata[29:15] == out_tdata[14:0])
    else $error("snapped yaw differs from desired yaw");

  // Equal positions report a zero desired yaw
  a_equal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == htst_pkg::OUT_EQUAL) |-> out_tdata[14:0] == '0)
    else $error("equal positions with nonzero desired yaw");

  // Both yaw fields stay wrapped to one full turn
  a_yaw_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[14:0] < 15'(htst_pkg::FULL_TURN))
                && (out_tdata[29:15] < 15'(htst_pkg::FULL_TURN)))
    else $error("yaw outside one full turn");

endmodule
